>>> rtl/signed_pair_magnitude_assert.svh
// ----------------------------------------------------------------------------
// signed pair magnitude assertion macros
// shared concurrent assertion forms, all checked out of reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_PAIR_MAGNITUDE_ASSERT_SVH
`define SIGNED_PAIR_MAGNITUDE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// shared constants, format decode and the sideband word for the magnitude pipe
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

    localparam int SAMPLE_W          = 64;
    localparam int IDX_W             = 6;   // bit index into a sample port
    localparam int FMT_W             = 3;
    localparam int WIDTH_W           = 7;   // holds a sample width up to 64
    localparam int DEFAULT_MAX_WIDTH = 64;

    localparam logic [FMT_W-1:0] FMT_8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_24 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_64 = 3'd4;

    localparam logic [FMT_W-1:0] FMT_RESET = FMT_16;

    // control that travels alongside the data through every stage
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic               last;
        logic [WIDTH_W-1:0] width;
    } side_t;

    // unused codes fall back to 64 bit
    function automatic logic [WIDTH_W-1:0] width_of(input logic [FMT_W-1:0] fmt);
        logic [WIDTH_W-1:0] w;
        case (fmt)
            FMT_8:   w = 7'd8;
            FMT_16:  w = 7'd16;
            FMT_24:  w = 7'd24;
            FMT_32:  w = 7'd32;
            FMT_64:  w = 7'd64;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/spm_square.sv
// ----------------------------------------------------------------------------
// spm_square
// sign extension, sign decision and sum of squares in four registered stages
// ----------------------------------------------------------------------------
`default_nettype none

module spm_square #(
    parameter int MAX_W = spm_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                advance,
    input  wire                                in_valid,
    input  wire  [spm_pkg::SAMPLE_W-1:0]       sample_a,
    input  wire  [spm_pkg::SAMPLE_W-1:0]       sample_b,
    input  wire                                last_in,
    input  wire  [spm_pkg::FMT_W-1:0]          sample_format,
    output spm_pkg::side_t                     side_o,
    output logic [2*MAX_W-1:0]                 sum_o
);

    localparam int LO_W = (MAX_W + 1) / 2;
    localparam int HI_W = MAX_W - LO_W;
    localparam int SQ_W = 2 * MAX_W;

    // stage 0 input decode
    logic [spm_pkg::WIDTH_W-1:0] w_fmt;
    logic [spm_pkg::WIDTH_W-1:0] w_sel;
    logic [spm_pkg::WIDTH_W-1:0] w_m1;
    logic [spm_pkg::IDX_W-1:0]   sign_idx;
    logic [MAX_W-1:0]            a_ext;
    logic [MAX_W-1:0]            b_ext;
    logic [MAX_W:0]              sum_ab;

    spm_pkg::side_t   s0_side_reg, s0_side_next;
    spm_pkg::side_t   s1_side_reg;
    spm_pkg::side_t   s2_side_reg;
    spm_pkg::side_t   s3_side_reg;

    logic [MAX_W-1:0]     ma_reg, ma_next;
    logic [MAX_W-1:0]     mb_reg, mb_next;
    logic [2*LO_W-1:0]    a_ll_reg, a_ll_next, b_ll_reg, b_ll_next;
    logic [2*HI_W-1:0]    a_hh_reg, a_hh_next, b_hh_reg, b_hh_next;
    logic [LO_W+HI_W-1:0] a_hl_reg, a_hl_next, b_hl_reg, b_hl_next;
    logic [SQ_W-1:0]      sq_a_reg, sq_a_next, sq_b_reg, sq_b_next;
    logic [SQ_W-1:0]      sum_reg, sum_next;

    always_comb
    begin
        w_fmt    = spm_pkg::width_of(sample_format);
        w_sel    = (w_fmt > spm_pkg::WIDTH_W'(MAX_W)) ? spm_pkg::WIDTH_W'(MAX_W) : w_fmt;
        w_m1     = w_sel - 7'd1;
        sign_idx = w_m1[spm_pkg::IDX_W-1:0];
        for (int i = 0; i < MAX_W; i++)
        begin
            a_ext[i] = (spm_pkg::WIDTH_W'(i) < w_sel) ? sample_a[i] : sample_a[sign_idx];
            b_ext[i] = (spm_pkg::WIDTH_W'(i) < w_sel) ? sample_b[i] : sample_b[sign_idx];
        end
        // negative exactly when a + b is below zero
        sum_ab = {a_ext[MAX_W-1], a_ext} + {b_ext[MAX_W-1], b_ext};
        ma_next = a_ext[MAX_W-1] ? (MAX_W'(0) - a_ext) : a_ext;
        mb_next = b_ext[MAX_W-1] ? (MAX_W'(0) - b_ext) : b_ext;

        s0_side_next.valid = in_valid;
        s0_side_next.neg   = sum_ab[MAX_W];
        s0_side_next.last  = last_in;
        s0_side_next.width = w_sel;
    end

    // stage 1 partial products, each at most half width square
    always_comb
    begin
        a_ll_next = ma_reg[LO_W-1:0] * ma_reg[LO_W-1:0];
        a_hh_next = ma_reg[MAX_W-1:LO_W] * ma_reg[MAX_W-1:LO_W];
        a_hl_next = ma_reg[MAX_W-1:LO_W] * ma_reg[LO_W-1:0];
        b_ll_next = mb_reg[LO_W-1:0] * mb_reg[LO_W-1:0];
        b_hh_next = mb_reg[MAX_W-1:LO_W] * mb_reg[MAX_W-1:LO_W];
        b_hl_next = mb_reg[MAX_W-1:LO_W] * mb_reg[LO_W-1:0];
    end

    // stage 2 squares, cross term counts twice; stage 3 sum
    always_comb
    begin
        sq_a_next = {a_hh_reg, a_ll_reg} + (SQ_W'(a_hl_reg) << (LO_W + 1));
        sq_b_next = {b_hh_reg, b_ll_reg} + (SQ_W'(b_hl_reg) << (LO_W + 1));
        sum_next  = sq_a_reg + sq_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_side_reg <= '0;
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
        end
        else if (advance)
        begin
            s0_side_reg <= s0_side_next;
            s1_side_reg <= s0_side_reg;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            a_ll_reg <= a_ll_next;
            a_hh_reg <= a_hh_next;
            a_hl_reg <= a_hl_next;
            b_ll_reg <= b_ll_next;
            b_hh_reg <= b_hh_next;
            b_hl_reg <= b_hl_next;
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            sum_reg  <= sum_next;
        end
    end

    assign side_o = s3_side_reg;
    assign sum_o  = sum_reg;

endmodule

`default_nettype wire

>>> rtl/spm_root_cell.sv
// ----------------------------------------------------------------------------
// spm_root_cell
// one restoring square root step: brings down two radicand bits, emits one root bit
// ----------------------------------------------------------------------------
`default_nettype none

module spm_root_cell #(
    parameter int MAX_W = spm_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     advance,
    input  wire spm_pkg::side_t     side_i,
    input  wire  [2*MAX_W-1:0]      n_i,
    input  wire  [MAX_W+1:0]        rem_i,
    input  wire  [MAX_W-1:0]        root_i,
    output spm_pkg::side_t          side_o,
    output logic [2*MAX_W-1:0]      n_o,
    output logic [MAX_W+1:0]        rem_o,
    output logic [MAX_W-1:0]        root_o
);

    localparam int SQ_W  = 2 * MAX_W;
    localparam int REM_W = MAX_W + 2;

    spm_pkg::side_t   side_reg;
    logic [SQ_W-1:0]  n_reg, n_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MAX_W-1:0] root_reg, root_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // incoming remainder stays below 2^MAX_W, so its top two bits are free
    always_comb
    begin
        rem_sh    = {rem_i[REM_W-3:0], n_i[SQ_W-1 -: 2]};
        trial     = {root_i, 2'b01};
        diff      = {1'b0, rem_sh} - {1'b0, trial};
        ge        = !diff[REM_W];
        rem_next  = ge ? diff[REM_W-1:0] : rem_sh;
        root_next = {root_i[MAX_W-2:0], ge};
        n_next    = n_i << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (advance)
            side_reg <= side_i;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign side_o = side_reg;
    assign n_o    = n_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

`default_nettype wire

>>> rtl/spm_out_buf.sv
// ----------------------------------------------------------------------------
// spm_out_buf
// saturation and sign of the root, then a two word skid buffer to the output
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_pair_magnitude_assert.svh"

module spm_out_buf #(
    parameter int MAX_W = spm_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire spm_pkg::side_t           side_i,
    input  wire  [MAX_W-1:0]              root_i,
    output logic                          room,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [spm_pkg::SAMPLE_W-1:0]  magnitude_out,
    output logic                          last_out
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [spm_pkg::WIDTH_W-1:0]  w_m1;
    logic [MAX_W-1:0]             maxpos;
    logic [MAX_W-1:0]             sat;
    logic [spm_pkg::SAMPLE_W-1:0] mag_wide;
    logic [spm_pkg::SAMPLE_W-1:0] result;

    logic [spm_pkg::SAMPLE_W-1:0] mag_mem [2];
    logic                         last_mem [2];

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       pop;

    always_comb
    begin
        w_m1     = side_i.width - 7'd1;
        maxpos   = (MAX_W'(1) << w_m1) - MAX_W'(1);
        sat      = (root_i > maxpos) ? maxpos : root_i;
        mag_wide = spm_pkg::SAMPLE_W'(sat);
        result   = side_i.neg ? (spm_pkg::SAMPLE_W'(0) - mag_wide) : mag_wide;
    end

    assign room = (count_reg != DEPTH);
    assign push = side_i.valid && room;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_mem[wr_ptr_reg]  <= result;
            last_mem[wr_ptr_reg] <= side_i.last;
        end
    end

    assign out_valid     = (count_reg != 2'd0);
    assign magnitude_out = mag_mem[rd_ptr_reg];
    assign last_out      = last_mem[rd_ptr_reg];

    `SPM_ASSERT_NOW(a_no_overflow, clk, rst_n, push, count_reg != DEPTH, "word pushed into full buffer")
    `SPM_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1, "count missed a push")
    `SPM_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 2'd1, "count missed a pop")

endmodule

`default_nettype wire

>>> rtl/signed_pair_magnitude.sv
// From input accept to output valid a word passes through, in order:
//   four squaring stages, one root cell per result bit, one output buffer write.
// Throughput: one word per cycle; the whole pipe advances together and holds only
//   when its last cell carries a word and the two word output buffer is full.
// Reset: sample_format returns to 16 bit, every stage and the output buffer empty.
// ----------------------------------------------------------------------------
// signed_pair_magnitude
// signed floor root of a^2 + b^2 per sample pair, saturated to the sample format
// ----------------------------------------------------------------------------
`default_nettype none

module signed_pair_magnitude #(
    parameter int MAX_WIDTH = spm_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [spm_pkg::FMT_W-1:0]     cfg_wdata,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [spm_pkg::SAMPLE_W-1:0]  sample_a,
    input  wire  [spm_pkg::SAMPLE_W-1:0]  sample_b,
    input  wire                           last_in,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [spm_pkg::SAMPLE_W-1:0]  magnitude_out,
    output logic                          last_out
);

    localparam int SQ_W  = 2 * MAX_WIDTH;
    localparam int REM_W = MAX_WIDTH + 2;

    logic [spm_pkg::FMT_W-1:0] sample_format_reg, sample_format_next;
    logic                      advance;
    logic                      room;

    spm_pkg::side_t       link_side [MAX_WIDTH+1];
    logic [SQ_W-1:0]      link_n    [MAX_WIDTH+1];
    logic [REM_W-1:0]     link_rem  [MAX_WIDTH+1];
    logic [MAX_WIDTH-1:0] link_root [MAX_WIDTH+1];

    assign sample_format_next = cfg_we ? cfg_wdata : sample_format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_format_reg <= spm_pkg::FMT_RESET;
        else
            sample_format_reg <= sample_format_next;
    end

    // hold everything only when the last cell has a word with nowhere to go
    assign advance  = !link_side[MAX_WIDTH].valid || room;
    assign in_ready = advance;

    spm_square #(
        .MAX_W (MAX_WIDTH)
    ) u_square (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .last_in       (last_in),
        .sample_format (sample_format_reg),
        .side_o        (link_side[0]),
        .sum_o         (link_n[0])
    );

    assign link_rem[0]  = '0;
    assign link_root[0] = '0;

    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_cell
        spm_root_cell #(
            .MAX_W (MAX_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .side_i  (link_side[k]),
            .n_i     (link_n[k]),
            .rem_i   (link_rem[k]),
            .root_i  (link_root[k]),
            .side_o  (link_side[k+1]),
            .n_o     (link_n[k+1]),
            .rem_o   (link_rem[k+1]),
            .root_o  (link_root[k+1])
        );
    end

    spm_out_buf #(
        .MAX_W (MAX_WIDTH)
    ) u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_i        (link_side[MAX_WIDTH]),
        .root_i        (link_root[MAX_WIDTH]),
        .room          (room),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .magnitude_out (magnitude_out),
        .last_out      (last_out)
    );

endmodule

`default_nettype wire
